/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every check is clocked on i_clk and masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* src/flsa_pkg.sv */
// ----------------------------------------------------------------------------
// flsa_pkg
// Types, codes and constants shared by the slip angle filter controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package flsa_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int DIV_STEPS    = 16;

    localparam logic signed [25:0] DEG90_Q16 = 26'sd5898240;
    localparam logic signed [26:0] ANGLE_MAX = 27'sd46080;
    localparam logic [16:0]        CONF_ONE  = 17'd65536;
    localparam logic [16:0]        CONF_EPS  = 17'd65;

    // Reset values of the configuration registers
    localparam logic [15:0]        RST_SPEED_SCALE    = 16'd8043;
    localparam logic [14:0]        RST_CONF_LOW       = 15'd512;
    localparam logic [14:0]        RST_CONF_HIGH      = 15'd2048;
    localparam logic [15:0]        RST_STEP_MAX       = 16'd512;
    localparam logic [16:0]        RST_LIMIT_CONF_MIN = 17'd13107;
    localparam logic signed [23:0] RST_GATE_MIN_FWD   = 24'sd1280;
    localparam logic [22:0]        RST_GATE_MAX_LAT   = 23'd768;
    localparam logic [22:0]        RST_GATE_MAX_JUMP  = 23'd1280;

    typedef enum logic [2:0] {
        CFG_SPEED_SCALE    = 3'd0,
        CFG_CONF_LOW       = 3'd1,
        CFG_CONF_HIGH      = 3'd2,
        CFG_STEP_MAX       = 3'd3,
        CFG_LIMIT_CONF_MIN = 3'd4,
        CFG_GATE_MIN_FWD   = 3'd5,
        CFG_GATE_MAX_LAT   = 3'd6,
        CFG_GATE_MAX_JUMP  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_VX,
        OP_VY,
        OP_CINIT,
        OP_CITER,
        OP_DINIT,
        OP_DITER,
        OP_T2,
        OP_POLY,
        OP_CAND,
        OP_DECIDE,
        OP_EMAF,
        OP_EMAL,
        OP_COMMIT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VX,
        ST_VY,
        ST_CINIT,
        ST_CITER,
        ST_DINIT,
        ST_DITER,
        ST_T2,
        ST_POLY,
        ST_CAND,
        ST_DECIDE,
        ST_EMAF,
        ST_EMAL,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic emit;
    } t_status;

    // atan(2^-i) in units of 1/65536 degree
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/flsa_ctrl.sv */
// ----------------------------------------------------------------------------
// flsa_ctrl
// Sequencer for one word: steps the datapath through scaling, CORDIC,
// division, confidence, limiter, gate and EMA, and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flsa_ctrl
    import flsa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] DIV_LAST    = 5'(DIV_STEPS - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op    = OP_NONE;
        o_cmd.step  = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_VX;
                end
            end
            ST_VX: begin
                o_cmd.op = OP_VX;
                n_state  = ST_VY;
            end
            ST_VY: begin
                o_cmd.op = OP_VY;
                n_state  = ST_CINIT;
            end
            ST_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_cnt    = '0;
                n_state  = ST_CITER;
            end
            ST_CITER: begin
                o_cmd.op = OP_CITER;
                if (r_cnt == CORDIC_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DINIT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_state  = ST_DITER;
            end
            ST_DITER: begin
                o_cmd.op = OP_DITER;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_T2;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_T2: begin
                o_cmd.op = OP_T2;
                n_state  = ST_POLY;
            end
            ST_POLY: begin
                o_cmd.op = OP_POLY;
                n_state  = ST_CAND;
            end
            ST_CAND: begin
                o_cmd.op = OP_CAND;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = ST_EMAF;
            end
            ST_EMAF: begin
                // drop the word here when the gate holds it back
                if (i_status.emit) begin
                    o_cmd.op = OP_EMAF;
                    n_state  = ST_EMAL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMAL: begin
                o_cmd.op = OP_EMAL;
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register is free
                if (slot_free) begin
                    o_cmd.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    `ASSERT_NEVER(a_no_overwrite, (o_cmd.op == OP_COMMIT) && r_out_valid && i_stall,
        "result overwritten while stalled")
    `ASSERT_CLK(a_commit_emits, (r_state == ST_COMMIT) |-> i_status.emit,
        "commit without gate release")
    `ASSERT_CLK(a_cnt_range, (r_state == ST_CITER) |-> (r_cnt <= CORDIC_LAST),
        "CORDIC counter past table")

endmodule

`default_nettype wire

/* src/flsa_dp.sv */
// ----------------------------------------------------------------------------
// flsa_dp
// Datapath: configuration registers, shared multiplier, CORDIC, restoring
// divider, limiter, startup gate, EMA state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flsa_dp
    import flsa_pkg::*;
#(
    parameter int MAX_REF_GAP   = 3,
    parameter int LOCK_RUN      = 3,
    parameter int ALPHA_FWD_Q16 = 26214,
    parameter int ALPHA_LAT_Q16 = 13107
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic               i_cfg_valid,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic signed [15:0] i_flow_horiz,
    input  wire logic signed [15:0] i_flow_vert,
    output logic signed [23:0]      o_fwd_speed,
    output logic signed [23:0]      o_lat_speed,
    output logic signed [16:0]      o_angle_final,
    output logic signed [16:0]      o_angle_raw,
    output logic [16:0]             o_angle_conf,
    output logic                    o_angle_was_limited
);

    localparam logic [16:0] ALPHA_F  = 17'(ALPHA_FWD_Q16);
    localparam logic [16:0] ALPHA_L  = 17'(ALPHA_LAT_Q16);
    localparam logic [7:0]  GAP_MAX  = 8'(MAX_REF_GAP);
    localparam logic [7:0]  RUN_LOCK = 8'(LOCK_RUN);

    // configuration
    logic [15:0]        r_speed_scale;
    logic [14:0]        r_conf_low;
    logic [14:0]        r_conf_high;
    logic [15:0]        r_step_max;
    logic [16:0]        r_limit_conf_min;
    logic signed [23:0] r_gate_min_fwd;
    logic [22:0]        r_gate_max_lat;
    logic [22:0]        r_gate_max_jump;

    // per-word working registers
    logic signed [16:0] r_fwd, r_lat;
    logic signed [20:0] r_vx, r_vy;
    logic signed [31:0] r_cx, r_cy;
    logic signed [25:0] r_cz;
    logic signed [16:0] r_raw;
    logic [15:0]        r_rem, r_den, r_q;
    logic [16:0]        r_t;
    logic [32:0]        r_t2;
    logic [16:0]        r_conf;
    logic signed [16:0] r_cand, r_fin;
    logic               r_limited;
    logic               r_emit;
    logic signed [32:0] r_dfwd, r_dlat;

    // state kept across words
    logic               r_gate_locked;
    logic [7:0]         r_valid_run;
    logic [7:0]         r_frames_since;
    logic               r_ref_present;
    logic signed [23:0] r_speed_ref;
    logic signed [16:0] r_angle_prev;
    logic               r_angle_prev_valid;
    logic signed [31:0] r_ema_fwd, r_ema_lat;
    logic               r_ema_started;

    // ---------------- configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale    <= RST_SPEED_SCALE;
            r_conf_low       <= RST_CONF_LOW;
            r_conf_high      <= RST_CONF_HIGH;
            r_step_max       <= RST_STEP_MAX;
            r_limit_conf_min <= RST_LIMIT_CONF_MIN;
            r_gate_min_fwd   <= RST_GATE_MIN_FWD;
            r_gate_max_lat   <= RST_GATE_MAX_LAT;
            r_gate_max_jump  <= RST_GATE_MAX_JUMP;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_SCALE:    r_speed_scale    <= i_cfg_data[15:0];
                CFG_CONF_LOW:       r_conf_low       <= i_cfg_data[14:0];
                CFG_CONF_HIGH:      r_conf_high      <= i_cfg_data[14:0];
                CFG_STEP_MAX:       r_step_max       <= i_cfg_data[15:0];
                CFG_LIMIT_CONF_MIN: r_limit_conf_min <= i_cfg_data[16:0];
                CFG_GATE_MIN_FWD:   r_gate_min_fwd   <= $signed(i_cfg_data);
                CFG_GATE_MAX_LAT:   r_gate_max_lat   <= i_cfg_data[22:0];
                CFG_GATE_MAX_JUMP:  r_gate_max_jump  <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // ---------------- shared multiplier
    logic signed [33:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [52:0] prod;
    logic [16:0]        t_sel;
    logic [17:0]        poly;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_VX: begin
                mul_a = {{17{r_fwd[16]}}, r_fwd};
                mul_b = $signed({3'b000, r_speed_scale});
            end
            OP_VY: begin
                mul_a = {{17{r_lat[16]}}, r_lat};
                mul_b = $signed({3'b000, r_speed_scale});
            end
            OP_T2: begin
                mul_a = $signed({17'd0, t_sel});
                mul_b = $signed({2'b00, t_sel});
            end
            OP_POLY: begin
                mul_a = $signed({1'b0, r_t2});
                mul_b = $signed({1'b0, poly});
            end
            OP_CAND: begin
                mul_a = {{17{r_raw[16]}}, r_raw};
                mul_b = $signed({2'b00, r_conf});
            end
            OP_EMAF: begin
                mul_a = {r_dfwd[32], r_dfwd};
                mul_b = $signed({2'b00, ALPHA_F});
            end
            OP_EMAL: begin
                mul_a = {r_dlat[32], r_dlat};
                mul_b = $signed({2'b00, ALPHA_L});
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    logic signed [52:0] prod_r12, prod_r16, prod_r32;
    assign prod_r12 = prod + 53'sd2048;
    assign prod_r16 = prod + 53'sd32768;
    assign prod_r32 = prod + 53'sd2147483648;

    // ---------------- confidence ramp
    logic [16:0] afwd;
    logic [16:0] fwd_abs;
    logic [15:0] hi_eff;

    assign fwd_abs = r_fwd[16] ? 17'(-r_fwd) : 17'(r_fwd);
    assign afwd    = fwd_abs;
    assign hi_eff  = (r_conf_high <= r_conf_low) ? ({1'b0, r_conf_low} + 16'd256)
                                                 : {1'b0, r_conf_high};

    always_comb begin
        if (afwd <= {2'b00, r_conf_low}) begin
            t_sel = '0;
        end else if (afwd >= {1'b0, hi_eff}) begin
            t_sel = CONF_ONE;
        end else begin
            t_sel = {1'b0, r_q};
        end
    end

    assign poly = 18'd196608 - {r_t, 1'b0};

    // ---------------- CORDIC
    logic signed [31:0] x0, y0, ysh, xsh;
    logic [21:0]        atan_v;
    logic signed [26:0] zsum, zsh;
    logic signed [16:0] raw_n;

    assign x0     = {{3{r_fwd[16]}}, r_fwd, 12'd0};
    assign y0     = {{3{r_lat[16]}}, r_lat, 12'd0};
    assign ysh    = r_cy >>> i_cmd.step;
    assign xsh    = r_cx >>> i_cmd.step;
    assign atan_v = atan_q16(i_cmd.step);
    assign zsum   = {r_cz[25], r_cz} + 27'sd128;
    assign zsh    = zsum >>> 8;

    always_comb begin
        if (r_fwd == '0 && r_lat == '0) begin
            raw_n = '0;
        end else if (zsh > ANGLE_MAX) begin
            raw_n = ANGLE_MAX[16:0];
        end else if (zsh < -ANGLE_MAX) begin
            raw_n = 17'(-ANGLE_MAX);
        end else begin
            raw_n = zsh[16:0];
        end
    end

    // ---------------- divider step
    logic [16:0] rem2;
    logic        rem_ge;
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_den};

    // ---------------- limiter
    logic [16:0]        cmin;
    logic               use_lim;
    logic signed [17:0] dang, fin_l;
    logic [17:0]        dabs;
    logic               over;
    logic signed [16:0] fin_n;

    assign cmin    = (r_limit_conf_min > CONF_ONE) ? CONF_ONE : r_limit_conf_min;
    assign use_lim = r_conf >= cmin;
    assign dang    = {r_cand[16], r_cand} - {r_angle_prev[16], r_angle_prev};
    assign dabs    = dang[17] ? 18'(-dang) : 18'(dang);
    assign over    = r_angle_prev_valid && (dabs > {2'b00, r_step_max});
    assign fin_l   = {r_angle_prev[16], r_angle_prev}
                   + (dang[17] ? -$signed({2'b00, r_step_max}) : $signed({2'b00, r_step_max}));
    // low confidence passes the candidate through untouched
    assign fin_n   = (use_lim && over) ? fin_l[16:0] : r_cand;

    // ---------------- startup gate
    logic [7:0]         gap;
    logic               fresh, ok;
    logic signed [24:0] dvx;
    logic [24:0]        dvx_abs;
    logic [20:0]        vy_abs;
    logic [7:0]         run_inc;

    assign gap     = (r_frames_since == 8'hFF) ? 8'hFF : r_frames_since + 8'd1;
    assign fresh   = r_ref_present && (gap <= GAP_MAX);
    assign dvx     = {{4{r_vx[20]}}, r_vx} - {r_speed_ref[23], r_speed_ref};
    assign dvx_abs = dvx[24] ? 25'(-dvx) : 25'(dvx);
    assign vy_abs  = r_vy[20] ? 21'(-r_vy) : 21'(r_vy);
    assign ok      = ($signed({{3{r_vx[20]}}, r_vx}) >= r_gate_min_fwd)
                  && ({2'b00, vy_abs} <= r_gate_max_lat)
                  && (!fresh || (dvx_abs <= {2'b00, r_gate_max_jump}));
    assign run_inc = (r_valid_run == 8'hFF) ? 8'hFF : r_valid_run + 8'd1;

    // ---------------- EMA
    logic signed [28:0] tgt_fwd, tgt_lat;
    logic signed [31:0] ema_inc;
    logic signed [32:0] efwd_sum, elat_sum;

    assign tgt_fwd  = {r_vx, 8'd0};
    assign tgt_lat  = {r_vy, 8'd0};
    assign ema_inc  = prod_r16[47:16];
    assign efwd_sum = {r_ema_fwd[31], r_ema_fwd} + 33'sd128;
    assign elat_sum = {r_ema_lat[31], r_ema_lat} + 33'sd128;

    // ---------------- working registers (no reset)
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_fwd <= -{i_flow_vert[15], i_flow_vert};
                r_lat <= -{i_flow_horiz[15], i_flow_horiz};
            end
            OP_VX: r_vx <= prod_r12[32:12];
            OP_VY: r_vy <= prod_r12[32:12];
            OP_CINIT: begin
                if (r_fwd[16]) begin
                    if (!r_lat[16]) begin
                        r_cx <= y0;
                        r_cy <= -x0;
                        r_cz <= DEG90_Q16;
                    end else begin
                        r_cx <= -y0;
                        r_cy <= x0;
                        r_cz <= -DEG90_Q16;
                    end
                end else begin
                    r_cx <= x0;
                    r_cy <= y0;
                    r_cz <= '0;
                end
            end
            OP_CITER: begin
                if (!r_cy[31]) begin
                    r_cx <= r_cx + ysh;
                    r_cy <= r_cy - xsh;
                    r_cz <= r_cz + $signed({4'd0, atan_v});
                end else begin
                    r_cx <= r_cx - ysh;
                    r_cy <= r_cy + xsh;
                    r_cz <= r_cz - $signed({4'd0, atan_v});
                end
            end
            OP_DINIT: begin
                r_raw <= raw_n;
                r_rem <= 16'(afwd - {2'b00, r_conf_low});
                r_den <= hi_eff - {1'b0, r_conf_low};
                r_q   <= '0;
            end
            OP_DITER: begin
                r_rem <= rem_ge ? 16'(rem2 - {1'b0, r_den}) : rem2[15:0];
                r_q   <= {r_q[14:0], rem_ge};
            end
            OP_T2: begin
                r_t  <= t_sel;
                r_t2 <= prod[32:0];
            end
            OP_POLY: r_conf <= prod_r32[48:32];
            OP_CAND: r_cand <= prod_r16[32:16];
            OP_DECIDE: begin
                r_fin     <= fin_n;
                r_limited <= use_lim && over;
                r_dfwd    <= 33'(tgt_fwd) - 33'(r_ema_fwd);
                r_dlat    <= 33'(tgt_lat) - 33'(r_ema_lat);
            end
            default: ;
        endcase
    end

    // ---------------- state kept across words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_locked      <= 1'b0;
            r_valid_run        <= '0;
            r_frames_since     <= '0;
            r_ref_present      <= 1'b0;
            r_speed_ref        <= '0;
            r_angle_prev       <= '0;
            r_angle_prev_valid <= 1'b0;
            r_ema_fwd          <= '0;
            r_ema_lat          <= '0;
            r_ema_started      <= 1'b0;
            r_emit             <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_DECIDE: begin
                    if (use_lim) begin
                        r_angle_prev       <= fin_n;
                        r_angle_prev_valid <= 1'b1;
                    end else if (r_conf <= CONF_EPS) begin
                        r_angle_prev       <= '0;
                        r_angle_prev_valid <= 1'b0;
                    end
                    if (r_gate_locked) begin
                        r_emit <= 1'b1;
                    end else if (!ok) begin
                        r_valid_run    <= '0;
                        r_frames_since <= gap;
                        r_emit         <= 1'b0;
                    end else begin
                        r_speed_ref    <= 24'(r_vx);
                        r_ref_present  <= 1'b1;
                        r_frames_since <= '0;
                        r_valid_run    <= run_inc;
                        r_gate_locked  <= (run_inc >= RUN_LOCK);
                        r_emit         <= (run_inc >= RUN_LOCK);
                    end
                end
                OP_EMAF: begin
                    r_ema_fwd <= r_ema_started ? r_ema_fwd + ema_inc : 32'(tgt_fwd);
                end
                OP_EMAL: begin
                    r_ema_lat     <= r_ema_started ? r_ema_lat + ema_inc : 32'(tgt_lat);
                    r_ema_started <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_COMMIT) begin
            o_fwd_speed         <= efwd_sum[31:8];
            o_lat_speed         <= elat_sum[31:8];
            o_angle_final       <= r_fin;
            o_angle_raw         <= r_raw;
            o_angle_conf        <= r_conf;
            o_angle_was_limited <= r_limited;
        end
    end

    assign o_status.emit = r_emit;

    `ASSERT_CLK(a_conf_range, (i_cmd.op == OP_POLY) |=> (r_conf <= CONF_ONE),
        "confidence above one")
    `ASSERT_CLK(a_raw_range,
        (i_cmd.op == OP_DINIT) |=> ((r_raw <= 17'sd46080) && (r_raw >= -17'sd46080)),
        "raw angle out of range")
    `ASSERT_CLK(a_den_nonzero, (i_cmd.op == OP_DITER) |-> (r_den != '0),
        "divider run with zero denominator")

endmodule

`default_nettype wire

/* src/flow_speed_slip_angle_filter_core.sv */
// ----------------------------------------------------------------------------
// flow_speed_slip_angle_filter_core
// Turns one mean optical-flow word per frame into smoothed forward/lateral
// speed and a confidence-weighted, jump-limited slip angle.
// ----------------------------------------------------------------------------
// One input word is processed at a time. A word that the startup gate holds
// back is dropped before the EMA steps; a word that yields a result also runs
// the EMA and commit steps, and waits at commit while the result side stalls
// on the previous result. Each word runs the 18-step CORDIC and the 16-step
// restoring divider for the confidence ramp, both on a shared datapath, with
// one shared 34x19 multiplier for the scaling, smoothstep, weighting and EMA
// steps. A finished result sits in the output register, so the next word is
// taken while it waits. Configuration writes are always ready and must only
// be issued while no word is in flight.
`default_nettype none

module flow_speed_slip_angle_filter_core
    import flsa_pkg::*;
#(
    parameter int MAX_REF_GAP   = 3,     // 1..254 frames a speed reference stays fresh
    parameter int LOCK_RUN      = 3,     // 1..255 passing frames needed to lock
    parameter int ALPHA_FWD_Q16 = 26214, // forward EMA weight, Q0.16
    parameter int ALPHA_LAT_Q16 = 13107  // lateral EMA weight, Q0.16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input word channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_flow_horiz,
    input  wire logic signed [15:0] i_flow_vert,
    // result word channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [23:0]      o_fwd_speed,
    output logic signed [23:0]      o_lat_speed,
    output logic signed [16:0]      o_angle_final,
    output logic signed [16:0]      o_angle_raw,
    output logic [16:0]             o_angle_conf,
    output logic                    o_angle_was_limited,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    // register file accepts a write every cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer: advance one step per cycle, hold on a full output register
    flsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic, filter state and output register
    flsa_dp #(
        .MAX_REF_GAP   (MAX_REF_GAP),
        .LOCK_RUN      (LOCK_RUN),
        .ALPHA_FWD_Q16 (ALPHA_FWD_Q16),
        .ALPHA_LAT_Q16 (ALPHA_LAT_Q16)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_valid         (cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_flow_horiz        (i_flow_horiz),
        .i_flow_vert         (i_flow_vert),
        .o_fwd_speed         (o_fwd_speed),
        .o_lat_speed         (o_lat_speed),
        .o_angle_final       (o_angle_final),
        .o_angle_raw         (o_angle_raw),
        .o_angle_conf        (o_angle_conf),
        .o_angle_was_limited (o_angle_was_limited)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives flow words into the slip angle filter with random bursts and result
// stalls, predicts every result with a behavioral copy of the filter, and
// checks the results in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import flsa_pkg::*;
();

    localparam int MAX_REF_GAP   = 3;
    localparam int LOCK_RUN      = 3;
    localparam int ALPHA_FWD_Q16 = 26214;
    localparam int ALPHA_LAT_Q16 = 13107;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic signed [23:0] fwd_speed;
        logic signed [23:0] lat_speed;
        logic signed [16:0] angle_final;
        logic signed [16:0] angle_raw;
        logic [16:0]        angle_conf;
        logic               was_limited;
    } t_filter_out;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    wire logic               o_stall;
    logic signed [15:0]      i_flow_horiz;
    logic signed [15:0]      i_flow_vert;
    wire logic               o_valid;
    logic                    i_stall;
    wire logic signed [23:0] o_fwd_speed;
    wire logic signed [23:0] o_lat_speed;
    wire logic signed [16:0] o_angle_final;
    wire logic signed [16:0] o_angle_raw;
    wire logic [16:0]        o_angle_conf;
    wire logic               o_angle_was_limited;
    logic                    i_cfg_valid;
    wire logic               o_cfg_ready;
    logic [2:0]              i_cfg_index;
    logic [23:0]             i_cfg_data;

    flow_speed_slip_angle_filter_core #(
        .MAX_REF_GAP(MAX_REF_GAP), .LOCK_RUN(LOCK_RUN),
        .ALPHA_FWD_Q16(ALPHA_FWD_Q16), .ALPHA_LAT_Q16(ALPHA_LAT_Q16)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_flow_horiz(i_flow_horiz), .i_flow_vert(i_flow_vert),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_fwd_speed(o_fwd_speed), .o_lat_speed(o_lat_speed),
        .o_angle_final(o_angle_final), .o_angle_raw(o_angle_raw),
        .o_angle_conf(o_angle_conf), .o_angle_was_limited(o_angle_was_limited),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of configuration and filter state
    longint scale_q12, low_px, high_px, step_max, lim_thr, min_fwd, max_lat, max_jump;
    bit     locked, ref_present, prev_valid, ema_on;
    int     run_len, miss_gap;
    longint speed_ref, angle_prev, ema_fwd, ema_lat;

    t_filter_out expected_q[$];
    int          mismatches;
    bit          stall_mode;

    longint atan_lut[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("flow_speed_slip_angle_filter_core regression: fail");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint slip_angle(longint fwd, longint lat);
        longint x, y, z, t, nx, ny;
        x = fwd * 4096;
        y = lat * 4096;
        z = 0;
        if (fwd == 0 && lat == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 5898240;
            end else begin
                x = -y; y = t; z = -5898240;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_lut[i];
            end else begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_lut[i];
            end
            x = nx; y = ny;
        end
        z = asr(z + 128, 8);
        if (z > 46080) z = 46080;
        if (z < -46080) z = -46080;
        return z;
    endfunction

    function automatic longint ema_step(ref longint acc, input longint v, input longint alpha);
        longint target;
        target = v * 256;
        if (!ema_on) acc = target;
        else acc += asr(alpha * (target - acc) + 32768, 16);
        return asr(acc + 128, 8);
    endfunction

    // Advance the filter by one flow word; push a result when one is due.
    function automatic void predict_frame(logic signed [15:0] fh, logic signed [15:0] fv);
        longint fwd, lat, vx, vy, raw, afwd, lo, hi, t, conf, cand, fin, cmin, d, dvx;
        longint unsigned t2, poly;
        bit limited, fresh, ok;
        int gap;
        t_filter_out r;
        fwd = -longint'(fv);
        lat = -longint'(fh);
        vx = asr(fwd * scale_q12 + 2048, 12);
        vy = asr(lat * scale_q12 + 2048, 12);
        raw = slip_angle(fwd, lat);
        afwd = mag(fwd);
        lo = low_px;
        hi = high_px;
        limited = 0;
        if (hi <= lo) hi = lo + 256;
        if (afwd <= lo) t = 0;
        else if (afwd >= hi) t = 65536;
        else t = ((afwd - lo) * 65536) / (hi - lo);
        t2 = t * t;
        poly = 196608 - 2 * t;
        conf = longint'((t2 * poly + 64'd2147483648) >> 32);
        cand = asr(conf * raw + 32768, 16);
        cmin = lim_thr > 65536 ? 65536 : lim_thr;
        fin = cand;
        if (conf >= cmin) begin
            if (prev_valid) begin
                d = cand - angle_prev;
                if (mag(d) > step_max) begin
                    fin = angle_prev + (d < 0 ? -step_max : step_max);
                    limited = 1;
                end
            end
            angle_prev = fin;
            prev_valid = 1;
        end else if (conf <= 65) begin
            angle_prev = 0;
            prev_valid = 0;
        end
        if (!locked) begin
            gap = miss_gap + 1;
            if (gap > 255) gap = 255;
            fresh = ref_present && gap <= MAX_REF_GAP;
            dvx = fresh ? mag(vx - speed_ref) : 0;
            ok = vx >= min_fwd && mag(vy) <= max_lat && dvx <= max_jump;
            if (!ok) begin
                run_len = 0;
                miss_gap = gap;
                return;
            end
            speed_ref = vx;
            ref_present = 1;
            miss_gap = 0;
            if (run_len < 255) run_len++;
            if (run_len < LOCK_RUN) return;
            locked = 1;
        end
        r.fwd_speed   = 24'(ema_step(ema_fwd, vx, ALPHA_FWD_Q16));
        r.lat_speed   = 24'(ema_step(ema_lat, vy, ALPHA_LAT_Q16));
        ema_on        = 1;
        r.angle_final = 17'(fin);
        r.angle_raw   = 17'(raw);
        r.angle_conf  = 17'(conf);
        r.was_limited = limited;
        expected_q.push_back(r);
    endfunction

    // Reset state mirrors the block's reset
    initial begin
        scale_q12 = RST_SPEED_SCALE; low_px = RST_CONF_LOW; high_px = RST_CONF_HIGH;
        step_max = RST_STEP_MAX; lim_thr = RST_LIMIT_CONF_MIN;
        min_fwd = RST_GATE_MIN_FWD; max_lat = RST_GATE_MAX_LAT;
        max_jump = RST_GATE_MAX_JUMP;
        locked = 0; run_len = 0; miss_gap = 0; ref_present = 0; speed_ref = 0;
        angle_prev = 0; prev_valid = 0; ema_fwd = 0; ema_lat = 0; ema_on = 0;
    end

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_filter_out got, exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_fwd_speed, o_lat_speed, o_angle_final, o_angle_raw,
                       o_angle_conf, o_angle_was_limited};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp fwd %0d lat %0d fin %0d raw %0d conf %0d lim %0b",
                                exp_r.fwd_speed, exp_r.lat_speed, exp_r.angle_final,
                                exp_r.angle_raw, exp_r.angle_conf, exp_r.was_limited);
                            $display("          got fwd %0d lat %0d fin %0d raw %0d conf %0d lim %0b",
                                got.fwd_speed, got.lat_speed, got.angle_final,
                                got.angle_raw, got.angle_conf, got.was_limited);
                        end
                    end
                end
            end
            // Stall at random in both modes, often in one and rarely in the other
            if (stall_mode) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= ($urandom_range(0, 99) < 2);
        end
    end

    initial stall_mode = 0;

    int burst_left;

    // Send one flow word; gaps between random-length bursts.
    task automatic send_flow(logic signed [15:0] fh, logic signed [15:0] fv);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (idle > 0) begin
                i_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_flow_horiz <= fh;
        i_flow_vert  <= fv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_frame(fh, fv);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SPEED_SCALE:    scale_q12 = val[15:0];
            CFG_CONF_LOW:       low_px    = val[14:0];
            CFG_CONF_HIGH:      high_px   = val[14:0];
            CFG_STEP_MAX:       step_max  = val[15:0];
            CFG_LIMIT_CONF_MIN: lim_thr   = val[16:0];
            CFG_GATE_MIN_FWD:   min_fwd   = longint'($signed(val));
            CFG_GATE_MAX_LAT:   max_lat   = val[22:0];
            CFG_GATE_MAX_JUMP:  max_jump  = val[22:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] sc, logic [14:0] lo, logic [14:0] hi,
                             logic [15:0] st, logic [16:0] cm, logic [23:0] mf,
                             logic [22:0] ml, logic [22:0] mj);
        write_reg(CFG_SPEED_SCALE, 24'(sc));
        write_reg(CFG_CONF_LOW, 24'(lo));
        write_reg(CFG_CONF_HIGH, 24'(hi));
        write_reg(CFG_STEP_MAX, 24'(st));
        write_reg(CFG_LIMIT_CONF_MIN, 24'(cm));
        write_reg(CFG_GATE_MIN_FWD, mf);
        write_reg(CFG_GATE_MAX_LAT, 24'(ml));
        write_reg(CFG_GATE_MAX_JUMP, 24'(mj));
        i_cfg_valid <= 1'b0;
    endtask

    // Plausible driving: flow_vert negative (forward motion), small lateral
    task automatic send_driving(int n, int fwd_c, int spread);
        int fv;
        for (int i = 0; i < n; i++) begin
            fv = -fwd_c + $urandom_range(0, 2 * spread) - spread;
            if (fv < -32768) fv = -32768;
            if (fv > 32767) fv = 32767;
            send_flow(16'($signed($urandom_range(0, 2 * spread)) - spread), 16'(fv));
        end
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_flow(16'($urandom), 16'($urandom));
    endtask

    // Walk the field extremes and angle special cases
    task automatic test_directed();
        send_flow(16'sd0, 16'sd0);             // zero vector
        send_flow(16'sd0, -16'sd32768);        // full-scale forward word, passes the gate
        send_driving(4, 1500, 10);
        send_flow(16'sd0, 16'sd0);             // zero vector again
        send_flow(16'sd0, 16'sd1000);          // straight back
        send_flow(16'sd300, 16'sd1000);
        send_flow(-16'sd300, 16'sd1000);
        send_flow(-16'sd32768, 16'sd32767);
        send_flow(16'sd32767, -16'sd32768);
        send_flow(-16'sd32768, -16'sd32768);
        send_flow(16'sd32767, 16'sd32767);
        send_flow(16'sd2000, -16'sd600);       // large angle at low confidence, limiter bypassed
        send_flow(-16'sd2000, -16'sd3000);
        send_flow(16'sd0, -16'sd512);          // conf at low edge
        send_flow(16'sd0, -16'sd2048);         // conf at high edge
        send_flow(16'sd100, -16'sd513);        // tiny confidence
        send_flow(-16'sd1, 16'sd1);
        drain_results();
    endtask

    // Fresh gate each time is not possible without reset; vary config instead
    task automatic test_config_extremes();
        write_all(16'hFFFF, 15'h7FFF, 15'h0, 16'd46080, 17'd65536,
                  24'h800000, 23'h7FFFFF, 23'h7FFFFF);
        send_noise(20);
        drain_results();
        write_all(16'h0, 15'h0, 15'h7FFF, 16'h0, 17'h1FFFF,
                  24'h7FFFFF, 23'h0, 23'h0);
        send_noise(20);
        drain_results();
        write_all(16'd4096, 15'd300, 15'd300, 16'd256, 17'd0,
                  24'hFFFFFF, 23'd1000, 23'd200);
        send_driving(20, 800, 400);
        drain_results();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            stall_mode = phase[0];
            write_all(16'($urandom), 15'($urandom_range(0, 3000)),
                      15'($urandom_range(0, 5000)), 16'($urandom_range(0, 46080)),
                      17'($urandom_range(0, 70000)), 24'($signed($urandom_range(0, 4000)) - 2000),
                      23'($urandom_range(0, 1 << 14)), 23'($urandom_range(0, 4000)));
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 4));
                else send_driving($urandom_range(2, 12), $urandom_range(0, 6000),
                                  $urandom_range(1, 1500));
            end
            drain_results();
        end
    endtask

    initial begin
        mismatches   = 0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_flow_horiz = '0;
        i_flow_vert  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_SPEED_SCALE;
        i_cfg_data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        drain_results();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("flow_speed_slip_angle_filter_core regression: pass");
        else
            $display("flow_speed_slip_angle_filter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
